// File: rtl/core/pan_tilt_visual_servo_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// Pan/tilt tracker assertion macros
// Shared property templates for the tracker's assertion checker.
// ----------------------------------------------------------------------------
`ifndef PAN_TILT_VISUAL_SERVO_TRACKER_UNIT_DEFINES_SVH
`define PAN_TILT_VISUAL_SERVO_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTVST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTVST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define PTVST_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ptvst_pkg.sv
// ----------------------------------------------------------------------------
// Pan/tilt tracker package
// Payload types, configuration layout and fixed constants of the tracker.
// ----------------------------------------------------------------------------
package ptvst_pkg;

    // Fixed field widths.
    localparam int PIX_W      = 12;
    localparam int ANGLE_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int THR_W      = 8;
    localparam int TURN_W     = 15;
    localparam int STILL_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Command codes.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_DONE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_Y   = 3'd5;

    // Configuration reset values.
    localparam logic [PIX_W-1:0]  RST_CENTER_X = 12'd320;
    localparam logic [PIX_W-1:0]  RST_CENTER_Y = 12'd240;
    localparam logic [GAIN_W-1:0] RST_GAIN     = 16'd66;
    localparam logic [THR_W-1:0]  RST_MOVE_THR = 8'd10;
    localparam logic [TURN_W-1:0] RST_TURN_MIN = 15'd410;
    localparam logic              RST_FILTER_Y = 1'b0;

    // Still frame count at which the point is reported.
    localparam int REPORT_COUNT = 3;
    // Largest still count shown on the result.
    localparam int STILL_OUT_MAX = 7;

    // Gain product rounding: divide by 16, ties toward plus infinity.
    localparam int RND_SHIFT = 4;
    localparam int RND_BIAS  = 8;

    // Saturation limits of a Q3.12 angle.
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sh7FFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 16'sh8000;

    typedef struct packed {
        logic                      cmd;
        logic [PIX_W-1:0]          target_x;
        logic [PIX_W-1:0]          target_y;
        logic                      target_valid;
        logic signed [ANGLE_W-1:0] pan_pos;
        logic signed [ANGLE_W-1:0] lift_pos;
    } t_in_item;

    typedef struct packed {
        logic                      drive_valid;
        logic signed [ANGLE_W-1:0] pan_cmd;
        logic signed [ANGLE_W-1:0] lift_cmd;
        logic                      point_valid;
        logic [PIX_W-1:0]          point_x;
        logic [PIX_W-1:0]          point_y;
        logic                      base_turn_req;
        logic signed [ANGLE_W-1:0] base_angle;
        logic [STILL_W-1:0]        still_count;
    } t_out_item;

    typedef struct packed {
        logic [PIX_W-1:0]  center_x;
        logic [PIX_W-1:0]  center_y;
        logic [GAIN_W-1:0] gain;
        logic [THR_W-1:0]  move_threshold;
        logic [TURN_W-1:0] turn_min_angle;
        logic              filter_y;
    } t_cfg;

endpackage

// File: rtl/core/ptvst_cfg.sv
// ----------------------------------------------------------------------------
// Pan/tilt tracker configuration registers
// Holds the six setup registers written through the plain write port.
// ----------------------------------------------------------------------------
module ptvst_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptvst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptvst_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ptvst_pkg::t_cfg                     o_cfg
);

    ptvst_pkg::t_cfg r_cfg;

    // Register write decode; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x       <= ptvst_pkg::RST_CENTER_X;
            r_cfg.center_y       <= ptvst_pkg::RST_CENTER_Y;
            r_cfg.gain           <= ptvst_pkg::RST_GAIN;
            r_cfg.move_threshold <= ptvst_pkg::RST_MOVE_THR;
            r_cfg.turn_min_angle <= ptvst_pkg::RST_TURN_MIN;
            r_cfg.filter_y       <= ptvst_pkg::RST_FILTER_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptvst_pkg::CFG_CENTER_X: begin
                    r_cfg.center_x <= i_cfg_data[ptvst_pkg::PIX_W-1:0];
                end
                ptvst_pkg::CFG_CENTER_Y: begin
                    r_cfg.center_y <= i_cfg_data[ptvst_pkg::PIX_W-1:0];
                end
                ptvst_pkg::CFG_GAIN: begin
                    r_cfg.gain <= i_cfg_data[ptvst_pkg::GAIN_W-1:0];
                end
                ptvst_pkg::CFG_MOVE_THR: begin
                    r_cfg.move_threshold <= i_cfg_data[ptvst_pkg::THR_W-1:0];
                end
                ptvst_pkg::CFG_TURN_MIN: begin
                    r_cfg.turn_min_angle <= i_cfg_data[ptvst_pkg::TURN_W-1:0];
                end
                ptvst_pkg::CFG_FILTER_Y: begin
                    r_cfg.filter_y <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/ptvst_track.sv
// ----------------------------------------------------------------------------
// Pan/tilt tracker step logic
// Tracking state and the single-pass update that turns one item into one
// result: point hold, Y history mean, motion test, head drive, still count
// and base turn decision.
// ----------------------------------------------------------------------------
module ptvst_track #(
    parameter int HISTORY_DEPTH = 3,
    parameter int STILL_LIMIT   = 6,
    parameter int PIXEL_BITS    = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  ptvst_pkg::t_in_item  i_item,
    input  ptvst_pkg::t_cfg      i_cfg,
    output ptvst_pkg::t_out_item o_result
);

    localparam int PW     = PIXEL_BITS;
    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = PW + $clog2(HISTORY_DEPTH);
    // Mean by reciprocal multiply: exact for every SUM_W-bit sum.
    localparam int DIV_SH = SUM_W + $clog2(HISTORY_DEPTH);
    localparam logic [DIV_SH-1:0] RECIP =
        DIV_SH'(((64'd1 << DIV_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
    localparam int PROD_W = SUM_W + DIV_SH;
    // Pixel error and gain product widths.
    localparam int EXT_W  = (PW > ptvst_pkg::PIX_W) ? PW : ptvst_pkg::PIX_W;
    localparam int EW     = EXT_W + 1;
    localparam int PRW    = EW + ptvst_pkg::GAIN_W + 1;
    localparam int AW     = PRW + 1;
    localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
    localparam logic signed [AW-1:0] SAT_LO = AW'(-32768);
    // Squared distance width.
    localparam int DW     = 2 * PW + 3;
    // Still counter.
    localparam int SF_W   = $clog2(STILL_LIMIT + 2);
    localparam int SCW    = (SF_W > ptvst_pkg::STILL_W) ? SF_W : ptvst_pkg::STILL_W;
    localparam logic [SF_W-1:0] SF_LIMIT  = SF_W'(STILL_LIMIT);
    localparam logic [SF_W-1:0] SF_MAX    = SF_W'(STILL_LIMIT + 1);
    localparam logic [SF_W-1:0] SF_REPORT = SF_W'(ptvst_pkg::REPORT_COUNT);
    localparam logic [SCW-1:0]  SC_MAX    = SCW'(ptvst_pkg::STILL_OUT_MAX);

    // State.
    logic [PW-1:0]                        r_cur_x;
    logic [PW-1:0]                        r_cur_y;
    logic [PW-1:0]                        r_hist [HISTORY_DEPTH];
    logic [PW-1:0]                        r_mean;
    logic                                 r_hist_filled;
    logic [IDX_W-1:0]                     r_hist_idx;
    logic [SF_W-1:0]                      r_sf;
    logic                                 r_turn_pending;
    logic                                 r_aligned;
    logic signed [ptvst_pkg::ANGLE_W-1:0] r_turn_angle;

    // Next values.
    logic [PW-1:0]                        n_cur_x;
    logic [PW-1:0]                        n_cur_y;
    logic [PW-1:0]                        n_hist [HISTORY_DEPTH];
    logic [PW-1:0]                        n_mean;
    logic [IDX_W-1:0]                     n_hist_idx;
    logic [SF_W-1:0]                      n_sf;
    logic                                 n_turn_pending;
    logic                                 n_aligned;
    logic signed [ptvst_pkg::ANGLE_W-1:0] n_turn_angle;

    // Working signals.
    logic                                 frame;
    logic [PW-1:0]                        tx;
    logic [PW-1:0]                        ty;
    logic [PW-1:0]                        seed;
    logic [PW-1:0]                        prev_x;
    logic [PW-1:0]                        prev_y;
    logic [SUM_W-1:0]                     n_sum;
    logic [PROD_W-1:0]                    mean_prod;
    logic signed [PW:0]                   dx;
    logic signed [PW:0]                   dy;
    logic signed [2*PW+1:0]               dx2;
    logic signed [2*PW+1:0]               dy2;
    logic [DW-1:0]                        sq_dist;
    logic [2*ptvst_pkg::THR_W-1:0]        thr2;
    logic                                 motion;
    logic signed [EW-1:0]                 ex;
    logic signed [EW-1:0]                 ey;
    logic signed [ptvst_pkg::GAIN_W:0]    gain_s;
    logic signed [PRW-1:0]                px;
    logic signed [PRW-1:0]                py;
    logic signed [AW-1:0]                 rx;
    logic signed [AW-1:0]                 ry;
    logic signed [AW-1:0]                 pan_sum;
    logic signed [AW-1:0]                 lift_sum;
    logic signed [ptvst_pkg::ANGLE_W-1:0] pan_cmd;
    logic signed [ptvst_pkg::ANGLE_W-1:0] lift_cmd;
    logic signed [ptvst_pkg::ANGLE_W:0]   ta_ext;
    logic [ptvst_pkg::ANGLE_W:0]          turn_mag;
    logic [SCW-1:0]                       sf_wide;
    ptvst_pkg::t_out_item                 res;

    assign frame = (i_item.cmd == ptvst_pkg::CMD_FRAME);

    // Point selection and Y history update.
    always_comb begin
        tx     = PW'(i_item.target_x);
        ty     = PW'(i_item.target_y);
        seed   = i_item.target_valid ? ty : r_cur_y;
        prev_x = r_cur_x;
        if (i_cfg.filter_y) begin
            // Before the first frame the history is all seed, so its mean is the seed.
            prev_y = r_hist_filled ? r_mean : seed;
        end else begin
            prev_y = r_cur_y;
        end
        n_cur_x = i_item.target_valid ? tx : prev_x;
        n_cur_y = i_item.target_valid ? ty : prev_y;

        n_hist_idx = (r_hist_idx == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : r_hist_idx + 1'b1;
        n_sum = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            n_hist[i] = r_hist_filled ? r_hist[i] : seed;
            if (n_hist_idx == IDX_W'(i)) begin
                n_hist[i] = n_cur_y;
            end
            n_sum = n_sum + SUM_W'(n_hist[i]);
        end
        mean_prod = PROD_W'(n_sum) * PROD_W'(RECIP);
        n_mean    = mean_prod[DIV_SH +: PW];
    end

    // Motion test on squared pixel distance.
    always_comb begin
        dx      = signed'({1'b0, n_cur_x}) - signed'({1'b0, prev_x});
        dy      = signed'({1'b0, n_cur_y}) - signed'({1'b0, prev_y});
        dx2     = dx * dx;
        dy2     = dy * dy;
        sq_dist = DW'(unsigned'(dx2)) + DW'(unsigned'(dy2));
        thr2    = i_cfg.move_threshold * i_cfg.move_threshold;
        motion  = sq_dist > DW'(thr2);
    end

    // Proportional head drive with rounding and saturation.
    always_comb begin
        ex       = signed'({1'b0, EXT_W'(i_cfg.center_x)}) - signed'({1'b0, EXT_W'(n_cur_x)});
        ey       = signed'({1'b0, EXT_W'(i_cfg.center_y)}) - signed'({1'b0, EXT_W'(n_cur_y)});
        gain_s   = signed'({1'b0, i_cfg.gain});
        px       = ex * gain_s;
        py       = ey * gain_s;
        rx       = (AW'(px) + AW'(ptvst_pkg::RND_BIAS)) >>> ptvst_pkg::RND_SHIFT;
        ry       = (AW'(py) + AW'(ptvst_pkg::RND_BIAS)) >>> ptvst_pkg::RND_SHIFT;
        pan_sum  = AW'(i_item.pan_pos) + rx;
        lift_sum = AW'(i_item.lift_pos) - ry;
        if (pan_sum > SAT_HI) begin
            pan_cmd = ptvst_pkg::ANGLE_MAX;
        end else if (pan_sum < SAT_LO) begin
            pan_cmd = ptvst_pkg::ANGLE_MIN;
        end else begin
            pan_cmd = pan_sum[ptvst_pkg::ANGLE_W-1:0];
        end
        if (lift_sum > SAT_HI) begin
            lift_cmd = ptvst_pkg::ANGLE_MAX;
        end else if (lift_sum < SAT_LO) begin
            lift_cmd = ptvst_pkg::ANGLE_MIN;
        end else begin
            lift_cmd = lift_sum[ptvst_pkg::ANGLE_W-1:0];
        end
    end

    // Still counter, point report and base turn decision.
    always_comb begin
        n_sf           = r_sf;
        n_turn_pending = r_turn_pending;
        n_aligned      = r_aligned;
        n_turn_angle   = r_turn_angle;
        res            = '0;
        ta_ext         = '0;
        turn_mag       = '0;
        if (!frame) begin
            n_aligned = 1'b1;
        end else begin
            if (motion) begin
                n_sf            = '0;
                n_turn_angle    = pan_cmd;
                res.drive_valid = 1'b1;
                res.pan_cmd     = pan_cmd;
                res.lift_cmd    = lift_cmd;
            end else if (r_sf == SF_LIMIT) begin
                n_sf           = r_sf + 1'b1;
                n_turn_pending = 1'b1;
            end else if (r_sf < SF_MAX) begin
                n_sf = r_sf + 1'b1;
            end

            if ((n_sf == SF_REPORT) && r_aligned) begin
                res.point_valid = 1'b1;
                res.point_x     = ptvst_pkg::PIX_W'(n_cur_x);
                res.point_y     = ptvst_pkg::PIX_W'(n_cur_y);
            end

            if ((n_sf == SF_MAX) && n_turn_pending && !r_aligned) begin
                ta_ext   = (ptvst_pkg::ANGLE_W + 1)'(n_turn_angle);
                turn_mag = ta_ext[ptvst_pkg::ANGLE_W] ? unsigned'(-ta_ext) : unsigned'(ta_ext);
                if (turn_mag > (ptvst_pkg::ANGLE_W + 1)'(i_cfg.turn_min_angle)) begin
                    res.base_turn_req = 1'b1;
                    res.base_angle    = n_turn_angle;
                end else begin
                    // Turn too small to be worth it: the base counts as aligned.
                    n_sf      = '0;
                    n_aligned = 1'b1;
                end
                n_turn_pending = 1'b0;
            end
        end
        sf_wide         = SCW'(n_sf);
        res.still_count = (sf_wide > SC_MAX) ? ptvst_pkg::STILL_W'(ptvst_pkg::STILL_OUT_MAX)
                                             : sf_wide[ptvst_pkg::STILL_W-1:0];
    end

    assign o_result = res;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_hist_filled  <= 1'b0;
            r_hist_idx     <= '0;
            r_sf           <= '0;
            r_turn_pending <= 1'b0;
            r_aligned      <= 1'b0;
            r_turn_angle   <= '0;
        end else if (i_fire) begin
            r_sf           <= n_sf;
            r_turn_pending <= n_turn_pending;
            r_aligned      <= n_aligned;
            r_turn_angle   <= n_turn_angle;
            if (frame) begin
                r_cur_x       <= n_cur_x;
                r_cur_y       <= n_cur_y;
                r_hist_filled <= 1'b1;
                r_hist_idx    <= n_hist_idx;
            end
        end
    end

    // Y history and its mean; meaningful once the history is filled.
    always_ff @(posedge i_clk) begin
        if (i_fire && frame) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= n_hist[i];
            end
            r_mean <= n_mean;
        end
    end

endmodule

// File: rtl/core/pan_tilt_visual_servo_tracker_unit.sv
// ----------------------------------------------------------------------------
// Pan/tilt visual servo tracker
// Items enter on i_in (valid/ready): a frame with a target point and the
// head joint angles, or a base-alignment done event. Each item gives one
// result on o_out (valid/ready): head drive commands, a point report,
// a base-turn request and the still frame count.
// An accepted item lands in an input register; once the result register is
// free or draining, it is computed against the tracking state and loaded
// into the result register, which raises o_out_valid. One item per cycle is
// sustained while the receiver does not stall: the tracking state and
// result register update in the same cycle.
// When the receiver stalls, the result register holds and the input
// register keeps one more item; input ready drops only when both are full.
// Setup registers are written on i_cfg_we/i_cfg_idx/i_cfg_data at any
// edge and must only change while no item is in flight.
// Synchronous reset empties both registers, clears the tracking state and
// loads the setup registers with their defaults.
// ----------------------------------------------------------------------------
module pan_tilt_visual_servo_tracker_unit #(
    parameter int HISTORY_DEPTH = 3,
    parameter int STILL_LIMIT   = 6,
    parameter int PIXEL_BITS    = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ptvst_pkg::t_in_item              i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ptvst_pkg::t_out_item             o_out,
    input  logic                             i_cfg_we,
    input  logic [ptvst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptvst_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ptvst_pkg::t_cfg      cfg;
    ptvst_pkg::t_in_item  r_in;
    logic                 r_in_vld;
    ptvst_pkg::t_out_item r_out;
    logic                 r_out_vld;
    ptvst_pkg::t_out_item result;
    logic                 advance;

    ptvst_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ptvst_track #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .STILL_LIMIT   (STILL_LIMIT),
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // The held item is processed when the result register is free or draining.
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// File: rtl/core/ptvst_checker.sv
// ----------------------------------------------------------------------------
// Pan/tilt tracker port checker
// Watches the result channel of the tracker for reset, stall and field
// consistency; attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "pan_tilt_visual_servo_tracker_unit_defines.svh"

module ptvst_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input ptvst_pkg::t_out_item o_out
);

    // Reset leaves no result pending.
    `PTVST_ASSERT_NXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

    // A stalled result stays and does not change.
    `PTVST_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result changed")

    // Head commands are zero unless a drive is issued.
    `PTVST_ASSERT_IMP(a_drive_zero, i_clk, i_rst_n, o_out_valid && !o_out.drive_valid, (o_out.pan_cmd == 0) && (o_out.lift_cmd == 0), "drive fields set without drive")

    // A moving frame clears the still count, so it never also reports or turns.
    `PTVST_ASSERT_IMP(a_drive_excl, i_clk, i_rst_n, o_out_valid && o_out.drive_valid, !o_out.point_valid && !o_out.base_turn_req && (o_out.still_count == 0), "drive with report or turn")

    // Point and turn fields are zero unless flagged.
    `PTVST_ASSERT_IMP(a_report_zero, i_clk, i_rst_n, o_out_valid && !o_out.point_valid && !o_out.base_turn_req, (o_out.point_x == 0) && (o_out.point_y == 0) && (o_out.base_angle == 0), "report fields set without flag")

endmodule

bind pan_tilt_visual_servo_tracker_unit ptvst_checker u_ptvst_checker (.*);
